>>> rtl/rgp_pkg.sv
`default_nettype none
package rgp_pkg;

    // Field and register widths
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int COLOR_W = 8;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;

    // Default clamp for the image dimensions
    localparam int MAX_DIM_DEF = 1024;

    // Datapath widths, sized for any 11-bit dimension
    localparam int OFS_W  = 12;  // magnitude of a doubled center offset
    localparam int SQ_W   = 24;  // one squared offset
    localparam int SUM_W  = 24;  // s, the squared distance
    localparam int DEN_W  = 23;  // D, the squared diagonal
    localparam int E2_W   = 16;  // squared color span
    localparam int REM_W  = 40;  // dividend and running remainder
    localparam int QUO_W  = 16;  // quotient bits
    localparam int ROOT_W = 8;   // square root bits

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_START  = 2'd2,
        REG_END    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [COLOR_W-1:0] gray_level;
        logic               out_of_range;
    } t_pix_out;

endpackage
`default_nettype wire

>>> rtl/radial_gradient_pixel_top.sv
`default_nettype none
// Radial gradient pixel generator.
// Input channel (i_pix_valid / o_pix_stall / i_pix) carries one pixel
// coordinate per item; output channel (o_res_valid / i_res_stall / o_res)
// returns one item per coordinate: the gray level of a circular gradient
// running from start_color at the image center to end_color at the corner
// distance, or level 0 with out_of_range set for a coordinate off the image.
// The configuration port writes width, height, start and end colors by index;
// write it only while no item is in flight.
// Throughput is one item per clock while the output is not stalled: a
// 16-stage restoring divider (one quotient bit per stage) and an 8-stage
// square root (one root bit per stage) keep every stage short.
// Reset clears all valid bits and loads the register defaults
// (200 x 200, start 0, end 255). When the receiver stalls a valid result,
// the whole pipeline holds and o_pix_stall is raised; nothing is lost or
// repeated, and bubbles still move forward when the output is empty.
module radial_gradient_pixel_top #(
    parameter int MAX_DIM = rgp_pkg::MAX_DIM_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [rgp_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [rgp_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_pix_valid,
    output logic                           o_pix_stall,
    input  wire rgp_pkg::t_pix_in          i_pix,
    output logic                           o_res_valid,
    input  wire logic                      i_res_stall,
    output rgp_pkg::t_pix_out              o_res
);
    import rgp_pkg::*;

    localparam int DIV_STEPS = QUO_W;
    localparam int SQR_STEPS = ROOT_W;
    localparam int CLAMP_W   = 13;

    typedef struct packed {
        logic               vld;
        logic               oor;
        logic               neg;
        logic [OFS_W-1:0]   ax;
        logic [OFS_W-1:0]   ay;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [COLOR_W-1:0] e;
    } t_sa;

    typedef struct packed {
        logic               vld;
        logic               oor;
        logic               neg;
        logic [SQ_W-1:0]    sx;
        logic [SQ_W-1:0]    sy;
        logic [SQ_W-1:0]    ww;
        logic [SQ_W-1:0]    hh;
        logic [E2_W-1:0]    e2;
    } t_sb;

    typedef struct packed {
        logic               vld;
        logic               oor;
        logic               neg;
        logic [SUM_W-1:0]   s;
        logic [DEN_W-1:0]   d;
        logic [E2_W-1:0]    e2;
    } t_sc;

    typedef struct packed {
        logic               vld;
        logic               oor;
        logic               neg;
        logic [DEN_W-1:0]   d;
        logic [REM_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
    } t_div;

    typedef struct packed {
        logic               vld;
        logic               oor;
        logic               neg;
        logic [QUO_W-1:0]   quo;
        logic               rem_nz;
        logic [ROOT_W-1:0]  root;
        logic [QUO_W-1:0]   sq;
    } t_sqr;

    logic [DIM_W-1:0]   r_width, r_height;
    logic [COLOR_W-1:0] r_start, r_end;

    logic               r_in_vld;
    t_pix_in            r_in;
    t_sa                r_sa, n_sa;
    t_sb                r_sb, n_sb;
    t_sc                r_sc, n_sc;
    t_div               r_div [0:DIV_STEPS];
    t_div               n_div [0:DIV_STEPS];
    t_sqr               r_sqr [1:SQR_STEPS];
    t_sqr               n_sqr [0:SQR_STEPS];
    logic               r_out_vld;
    t_pix_out           r_out, n_out;

    logic               adv;
    logic [DIM_W-1:0]   w_c, h_c;
    logic [CLAMP_W:0]   ox, oy;

    // Advance the whole pipeline unless a finished item is held at the output
    assign adv         = !(r_out_vld && i_res_stall);
    assign o_pix_stall = !adv;
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(200);
            r_height <= DIM_W'(200);
            r_start  <= '0;
            r_end    <= '1;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_START:  r_start  <= i_cfg_data[COLOR_W-1:0];
                REG_END:    r_end    <= i_cfg_data[COLOR_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    // Clamp dimensions, range check, doubled center offsets, color span
    always_comb begin
        w_c = ({2'b0, r_width} > CLAMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_width;
        h_c = ({2'b0, r_height} > CLAMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;
        ox  = {3'b0, r_in.pixel_x, 1'b0} - {3'b0, w_c} + (CLAMP_W+1)'(1);
        oy  = {3'b0, r_in.pixel_y, 1'b0} - {3'b0, h_c} + (CLAMP_W+1)'(1);
        n_sa.vld = r_in_vld;
        n_sa.oor = ({1'b0, r_in.pixel_x} >= w_c) || ({1'b0, r_in.pixel_y} >= h_c);
        n_sa.neg = r_end < r_start;
        n_sa.ax  = ox[CLAMP_W] ? OFS_W'(-ox) : ox[OFS_W-1:0];
        n_sa.ay  = oy[CLAMP_W] ? OFS_W'(-oy) : oy[OFS_W-1:0];
        n_sa.w   = w_c;
        n_sa.h   = h_c;
        n_sa.e   = n_sa.neg ? (r_start - r_end) : (r_end - r_start);
    end

    // Square the offsets, dimensions and span
    always_comb begin
        n_sb.vld = r_sa.vld;
        n_sb.oor = r_sa.oor;
        n_sb.neg = r_sa.neg;
        n_sb.sx  = SQ_W'(r_sa.ax * r_sa.ax);
        n_sb.sy  = SQ_W'(r_sa.ay * r_sa.ay);
        n_sb.ww  = SQ_W'(r_sa.w * r_sa.w);
        n_sb.hh  = SQ_W'(r_sa.h * r_sa.h);
        n_sb.e2  = E2_W'(r_sa.e * r_sa.e);
    end

    // Sum to distance and diagonal
    always_comb begin
        n_sc.vld = r_sb.vld;
        n_sc.oor = r_sb.oor;
        n_sc.neg = r_sb.neg;
        n_sc.s   = SUM_W'(r_sb.sx + r_sb.sy);
        n_sc.d   = DEN_W'(r_sb.ww + r_sb.hh);
        n_sc.e2  = r_sb.e2;
    end

    // Form the dividend, then one quotient bit per stage
    always_comb begin
        logic [REM_W:0] trial;
        n_div[0].vld = r_sc.vld;
        n_div[0].oor = r_sc.oor;
        n_div[0].neg = r_sc.neg;
        n_div[0].d   = r_sc.d;
        n_div[0].rem = REM_W'(r_sc.e2 * r_sc.s);
        n_div[0].quo = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            n_div[i+1] = r_div[i];
            trial = {1'b0, r_div[i].rem}
                    - ((REM_W+1)'(r_div[i].d) << (DIV_STEPS-1-i));
            if (!trial[REM_W]) begin
                n_div[i+1].rem = trial[REM_W-1:0];
                n_div[i+1].quo[DIV_STEPS-1-i] = 1'b1;
            end
        end
    end

    // One root bit per stage, tracking the square of the root
    always_comb begin
        logic [ROOT_W-1:0] t;
        logic [QUO_W-1:0]  tt;
        n_sqr[0].vld    = r_div[DIV_STEPS].vld;
        n_sqr[0].oor    = r_div[DIV_STEPS].oor;
        n_sqr[0].neg    = r_div[DIV_STEPS].neg;
        n_sqr[0].quo    = r_div[DIV_STEPS].quo;
        n_sqr[0].rem_nz = |r_div[DIV_STEPS].rem;
        n_sqr[0].root   = '0;
        n_sqr[0].sq     = '0;
        for (int i = 1; i <= SQR_STEPS; i++) begin
            t  = ((i == 1) ? n_sqr[0].root : r_sqr[i-1].root)
                 | (ROOT_W'(1) << (SQR_STEPS-i));
            tt = QUO_W'(t * t);
            n_sqr[i] = (i == 1) ? n_sqr[0] : r_sqr[i-1];
            if (tt <= n_sqr[i].quo) begin
                n_sqr[i].root = t;
                n_sqr[i].sq   = tt;
            end
        end
    end

    // Round up for a falling gradient, then offset from the start color
    always_comb begin
        logic [COLOR_W-1:0] n_root;
        n_root = r_sqr[SQR_STEPS].root;
        if (r_sqr[SQR_STEPS].neg
            && (r_sqr[SQR_STEPS].sq != r_sqr[SQR_STEPS].quo
                || r_sqr[SQR_STEPS].rem_nz)) begin
            n_root = n_root + COLOR_W'(1);
        end
        n_out.out_of_range = r_sqr[SQR_STEPS].oor;
        if (r_sqr[SQR_STEPS].oor) begin
            n_out.gray_level = '0;
        end else if (r_sqr[SQR_STEPS].neg) begin
            n_out.gray_level = r_start - n_root;
        end else begin
            n_out.gray_level = r_start + n_root;
        end
    end

    // Advance valid bits and payload together; reset clears the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_sa.vld  <= 1'b0;
            r_sb.vld  <= 1'b0;
            r_sc.vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++) r_div[i].vld <= 1'b0;
            for (int i = 1; i <= SQR_STEPS; i++) r_sqr[i].vld <= 1'b0;
        end else if (adv) begin
            r_in_vld  <= i_pix_valid;
            r_in      <= i_pix;
            r_sa      <= n_sa;
            r_sb      <= n_sb;
            r_sc      <= n_sc;
            r_out_vld <= r_sqr[SQR_STEPS].vld;
            r_out     <= n_out;
            for (int i = 0; i <= DIV_STEPS; i++) r_div[i] <= n_div[i];
            for (int i = 1; i <= SQR_STEPS; i++) r_sqr[i] <= n_sqr[i];
        end
    end

    // Off-image items always carry level zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.out_of_range |-> r_out.gray_level == '0)
        else $error("off-image item with nonzero level");

    // Divider leaves a remainder below the diagonal for on-image items
    a_rem_lt_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div[DIV_STEPS].vld && !r_div[DIV_STEPS].oor
        |-> r_div[DIV_STEPS].rem < REM_W'(r_div[DIV_STEPS].d))
        else $error("divider remainder not reduced");

    // Root square never exceeds the quotient
    a_root_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sqr[SQR_STEPS].vld |-> r_sqr[SQR_STEPS].sq <= r_sqr[SQR_STEPS].quo)
        else $error("square root overshoots");

    // Input is held back only while a result waits at the output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_stall |-> r_out_vld && i_res_stall)
        else $error("input held without a waiting result");

    // A held pipeline keeps its divider contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_div[DIV_STEPS/2].rem))
        else $error("pipeline moved while held");

endmodule
`default_nettype wire
